/* rtl/sgfb_pkg.sv */
package sgfb_pkg;

    // Channel count and the address width of the per-channel state memory.
    localparam int CHANNELS = 64;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int CHAN_W     = 6;
    localparam int SAMPLE_W   = 24;
    localparam int OUT_W      = 26;
    localparam int C1_W       = 18;
    localparam int C2_W       = 17;
    localparam int RL_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Datapath widths: products of an 18-bit signed coefficient and a 24-bit sample,
    // and the sum of the sample and two rounded products.
    localparam int PROD_W = C1_W + SAMPLE_W;
    localparam int FRAC_W = 16;
    localparam int RND_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = OUT_W + 2;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));
    localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  SUM_MIN    = -SUM_MAX - SUM_W'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV1        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV2        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_LENGTH = 2'd2;

    // Configuration reset values.
    localparam logic [C1_W-1:0] COEF_PREV1_RST        = C1_W'(-128600);
    localparam logic [C2_W-1:0] COEF_PREV2_RST        = C2_W'(63065);
    localparam logic [RL_W-1:0] REFRACTORY_LENGTH_RST = RL_W'(4);

    // Commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SPIKE  = 1'b1;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One entry of the per-channel state memory.
    typedef struct packed {
        logic [SAMPLE_W-1:0] prev1;
        logic [SAMPLE_W-1:0] prev2;
        logic [RL_W-1:0]     count;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    // Item handed from the state update stage to the arithmetic stages.
    typedef struct packed {
        logic                valid;
        logic [CHAN_W-1:0]   channel;
        logic                gate;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] prev1;
        logic [SAMPLE_W-1:0] prev2;
    } mac_in_t;

    // One result item.
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [OUT_W-1:0]  value;
    } result_t;

endpackage

/* rtl/sgfb_ram.sv */
module sgfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Single write port, registered read port; a read of the entry being
    // written returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

/* rtl/sgfb_mac.sv */
module sgfb_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sgfb_pkg::mac_in_t                   in_item,
    input  logic [sgfb_pkg::C1_W-1:0]           coef_prev1,
    input  logic [sgfb_pkg::C2_W-1:0]           coef_prev2,
    output logic                                res_valid,
    output sgfb_pkg::result_t                   res
);
    import sgfb_pkg::*;

    logic                       valid_reg;
    logic [CHAN_W-1:0]          channel_reg;
    logic                       gate_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   prod1_reg;
    logic signed [PROD_W-1:0]   prod2_reg;
    logic signed [PROD_W-1:0]   prod1_next;
    logic signed [PROD_W-1:0]   prod2_next;
    logic signed [PROD_W-1:0]   prod1_rnd;
    logic signed [PROD_W-1:0]   prod2_rnd;
    logic signed [RND_W-1:0]    term1;
    logic signed [RND_W-1:0]    term2;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sat;

    // One multiplier per tap; the coefficient of the older tap is unsigned.
    // The product takes its full width from the left-hand side.
    assign prod1_next = $signed(coef_prev1) * $signed(in_item.prev1);
    assign prod2_next = $signed({1'b0, coef_prev2}) * $signed(in_item.prev2);

    // Product register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_item.valid;
        end
        channel_reg <= in_item.channel;
        gate_reg    <= in_item.gate;
        sample_reg  <= $signed(in_item.sample);
        prod1_reg   <= prod1_next;
        prod2_reg   <= prod2_next;
    end

    // Round each product to nearest (ties upward), then sum and saturate.
    assign prod1_rnd = prod1_reg + ROUND_HALF;
    assign prod2_rnd = prod2_reg + ROUND_HALF;
    assign term1     = prod1_rnd[PROD_W-1:FRAC_W];
    assign term2     = prod2_rnd[PROD_W-1:FRAC_W];
    assign sum       = SUM_W'(sample_reg) + SUM_W'(term1) + SUM_W'(term2);

    always_comb begin
        if (sum > SUM_MAX) begin
            sat = SUM_MAX;
        end else if (sum < SUM_MIN) begin
            sat = SUM_MIN;
        end else begin
            sat = sum;
        end
    end

    // The output is forced to zero while the channel is refractory.
    assign res_valid   = valid_reg;
    assign res.channel = channel_reg;
    assign res.value   = gate_reg ? '0 : sat[OUT_W-1:0];

endmodule

/* rtl/sgfb_out_fifo.sv */
module sgfb_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  sgfb_pkg::result_t                 push_data,
    input  logic                              pop_ready,
    output logic                              pop_valid,
    output sgfb_pkg::result_t                 pop_data,
    output logic [sgfb_pkg::FIFO_CW-1:0]      count
);
    import sgfb_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;
    assign count     = count_reg;

    // Occupancy follows pushes and pops; the upstream reserves room before an
    // item enters, so a push never meets a full queue.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/spike_gated_fir_filter_bank_unit.sv */
// Spike-gated bank of three-tap FIR filters, one per channel. A sample item
// (command 0) returns one result: the sample plus coef_prev1 times the
// channel's previous sample plus coef_prev2 times the sample before that, each
// product rounded to nearest, saturated to 26 bits, and forced to zero while
// the channel's refractory count (decremented on each sample) is nonzero. A
// spike item (command 1) clears the channel's history, loads the refractory
// count and returns nothing. The block takes one item per clock while the
// result queue has room; a result is offered after the memory read, then the
// multiply, then round, sum and result queue write, and a four-entry result
// queue lets input continue while results wait. Per-channel state sits in one
// single-port-write, registered-read memory with forwarding of the last write
// between consecutive items on the same channel; per-entry valid bits make all
// state read as zero after reset, so there is no clearing pass. Configuration
// registers may be written only while the block holds no item in flight.
module spike_gated_fir_filter_bank_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [sgfb_pkg::CHAN_W-1:0]         s_channel,
    input  logic [sgfb_pkg::SAMPLE_W-1:0]       s_sample_value,
    // Result items.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sgfb_pkg::CHAN_W-1:0]         m_out_channel,
    output logic [sgfb_pkg::OUT_W-1:0]          m_filtered_value,
    // Configuration writes.
    input  logic                                cfg_wr_en,
    input  logic [sgfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgfb_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import sgfb_pkg::*;

    // Configuration registers.
    logic [C1_W-1:0]      coef_prev1_reg;
    logic [C2_W-1:0]      coef_prev2_reg;
    logic [RL_W-1:0]      refr_len_reg;

    // Stage one: item waiting for its state read.
    logic                 v1_reg;
    logic                 cmd1_reg;
    logic [CHAN_W-1:0]    ch1_reg;
    logic [SAMPLE_W-1:0]  x1_reg;

    // Last write, kept for forwarding to the next item.
    logic                 wb_v_reg;
    logic [CHAN_W-1:0]    wb_ch_reg;
    chan_state_t          wb_state_reg;

    // Per-entry valid bits; an entry not yet written reads as zero.
    logic [CHANNELS-1:0]  valid_bits_reg;

    logic                 accept;
    logic                 ch_ok;
    logic [CH_AW-1:0]     rd_addr;
    logic [CH_AW-1:0]     addr1;
    logic [STATE_W-1:0]   ram_rdata;
    chan_state_t          cur_state;
    chan_state_t          new_state;
    logic [RL_W-1:0]      count_dec;
    mac_in_t              mac_in;
    logic                 res_valid;
    result_t              res;
    result_t              out_data;
    logic [FIFO_CW-1:0]   fifo_count;
    logic [FIFO_CW:0]     reserved;

    // Room is reserved in the result queue for every item in flight: samples
    // in stage one and items in the product stage.
    assign reserved = (FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'(mac_in.valid)
                    + (FIFO_CW+1)'(res_valid);
    assign s_ready  = (reserved < (FIFO_CW+1)'(FIFO_DEPTH));
    assign accept   = s_valid && s_ready;
    assign ch_ok    = (int'(s_channel) < CHANNELS);
    assign rd_addr  = CH_AW'(s_channel);
    assign addr1    = CH_AW'(ch1_reg);

    // Configuration write port; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_prev1_reg <= COEF_PREV1_RST;
            coef_prev2_reg <= COEF_PREV2_RST;
            refr_len_reg   <= REFRACTORY_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEF_PREV1: begin
                    coef_prev1_reg <= cfg_wr_data[C1_W-1:0];
                end
                REG_COEF_PREV2: begin
                    coef_prev2_reg <= cfg_wr_data[C2_W-1:0];
                end
                REG_REFRACTORY_LENGTH: begin
                    refr_len_reg <= cfg_wr_data[RL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage one capture; out-of-range channels never enter the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= accept && ch_ok;
        end
        cmd1_reg <= s_command;
        ch1_reg  <= s_channel;
        x1_reg   <= s_sample_value;
    end

    sgfb_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (v1_reg),
        .wr_addr (addr1),
        .wr_data (new_state),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Current state: forwarded from the previous item on the same channel,
    // else the memory, else zero for a never-written entry.
    always_comb begin
        if (wb_v_reg && (wb_ch_reg == ch1_reg)) begin
            cur_state = wb_state_reg;
        end else if (valid_bits_reg[addr1]) begin
            cur_state = chan_state_t'(ram_rdata);
        end else begin
            cur_state = '0;
        end
    end

    // State update: a spike clears history and loads the count; a sample
    // shifts history and counts down the refractory period.
    assign count_dec = (cur_state.count != '0) ? (cur_state.count - RL_W'(1)) : '0;

    always_comb begin
        if (cmd1_reg == CMD_SPIKE) begin
            new_state.prev1 = '0;
            new_state.prev2 = '0;
            new_state.count = refr_len_reg;
        end else begin
            new_state.prev1 = x1_reg;
            new_state.prev2 = cur_state.prev1;
            new_state.count = count_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_v_reg       <= 1'b0;
            valid_bits_reg <= '0;
        end else begin
            wb_v_reg <= v1_reg;
            if (v1_reg) begin
                valid_bits_reg[addr1] <= 1'b1;
            end
        end
        wb_ch_reg    <= ch1_reg;
        wb_state_reg <= new_state;
    end

    // Samples go on to the filter arithmetic.
    assign mac_in.valid   = v1_reg && (cmd1_reg == CMD_SAMPLE);
    assign mac_in.channel = ch1_reg;
    assign mac_in.gate    = (count_dec != '0);
    assign mac_in.sample  = x1_reg;
    assign mac_in.prev1   = cur_state.prev1;
    assign mac_in.prev2   = cur_state.prev2;

    sgfb_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_item    (mac_in),
        .coef_prev1 (coef_prev1_reg),
        .coef_prev2 (coef_prev2_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    sgfb_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_ready),
        .pop_valid (m_valid),
        .pop_data  (out_data),
        .count     (fifo_count)
    );

    assign m_out_channel    = out_data.channel;
    assign m_filtered_value = out_data.value;

endmodule

/* bench/tb_spike_gated_fir_filter_bank_unit.sv */
module tb_spike_gated_fir_filter_bank_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sgfb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CAP     = 20000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RX_HOLD       = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int PRESSURE_ITEMS = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [C1_W-1:0]     C1_MOST_NEG = {1'b1, {(C1_W-1){1'b0}}};
    localparam logic [C1_W-1:0]     C1_MOST_POS = {1'b0, {(C1_W-1){1'b1}}};
    localparam logic [C2_W-1:0]     C2_ALL_ONES = {C2_W{1'b1}};
    localparam logic [C2_W-1:0]     C2_UNITY    = C2_W'(65536);
    localparam logic [C1_W-1:0]     C1_HALF     = C1_W'(32768);
    localparam logic [C2_W-1:0]     C2_HALF     = C2_W'(32768);

    localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));

    typedef struct packed {
        logic                command;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } fir_item_t;

    // Ports of the block; every input starts at a known value.
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = 1'b0;
    logic [CHAN_W-1:0]     s_channel = '0;
    logic [SAMPLE_W-1:0]   s_sample_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_out_channel;
    logic [OUT_W-1:0]      m_filtered_value;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Predicted filter bank state and register copies.
    logic signed [SAMPLE_W-1:0] hist_prev1 [CHANNELS];
    logic signed [SAMPLE_W-1:0] hist_prev2 [CHANNELS];
    logic [RL_W-1:0]            refr_left  [CHANNELS];
    logic signed [C1_W-1:0]     w_prev1;
    logic [C2_W-1:0]            w_prev2;
    logic [RL_W-1:0]            refr_len;

    fir_item_t items_to_send [$];
    result_t   outputs_due   [$];
    fir_item_t tx_item;

    int mismatches   = 0;
    int cycle_count  = 0;
    int tx_gap       = 0;
    int tx_calm      = 0;
    bit tx_steady    = 1'b0;
    int rx_stall     = 0;
    int rx_calm      = 0;
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;

    spike_gated_fir_filter_bank_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_channel        (s_channel),
        .s_sample_value   (s_sample_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_channel    (m_out_channel),
        .m_filtered_value (m_filtered_value),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Run-away guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Product rounded to nearest with ties toward plus infinity.
    function automatic longint round_q16(input longint p);
        return (p + 32768) >>> FRAC_W;
    endfunction

    // Advances the predicted filter bank by one accepted item and queues any result.
    function automatic void fir_bank_step(input fir_item_t it);
        logic [CHAN_W-1:0] ch;
        longint            acc;
        result_t           r;
        ch = it.channel;
        if (it.command == CMD_SPIKE) begin
            hist_prev1[ch] = '0;
            hist_prev2[ch] = '0;
            refr_left[ch]  = refr_len;
            return;
        end
        if (refr_left[ch] != 0)
            refr_left[ch] = refr_left[ch] - 1'b1;
        acc = longint'($signed(it.sample))
            + round_q16(longint'(w_prev1) * longint'(hist_prev1[ch]))
            + round_q16(longint'(w_prev2) * longint'(hist_prev2[ch]));
        if (acc > OUT_HI)
            acc = OUT_HI;
        if (acc < OUT_LO)
            acc = OUT_LO;
        hist_prev2[ch] = hist_prev1[ch];
        hist_prev1[ch] = it.sample;
        // The history moves on even while the output is gated.
        if (refr_left[ch] != 0)
            acc = 0;
        r.channel = ch;
        r.value   = acc[OUT_W-1:0];
        outputs_due.push_back(r);
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 62)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Input driver: presents queued items and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                fir_bank_step(tx_item);
                tx_gap = tx_steady ? 0 : draw_gap(tx_calm);
            end
            if (s_valid && !s_ready) begin
                // Hold the item until it is taken.
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (items_to_send.size() > 0) begin
                tx_item = items_to_send.pop_front();
                s_valid        <= 1'b1;
                s_command      <= tx_item.command;
                s_channel      <= tx_item.channel;
                s_sample_value <= tx_item.sample;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted result and paces m_ready.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outputs_due.size() == 0) begin
                    report_mismatch($sformatf("result for channel %0d with nothing due",
                                              m_out_channel));
                end else begin
                    want = outputs_due.pop_front();
                    if (m_out_channel !== want.channel)
                        report_mismatch($sformatf("out_channel: got %0d, expected %0d",
                                                  m_out_channel, want.channel));
                    if (m_filtered_value !== want.value)
                        report_mismatch($sformatf("filtered_value ch %0d: got %0d, expected %0d",
                                                  want.channel, $signed(m_filtered_value),
                                                  $signed(want.value)));
                end
            end
            // A long hold-off requested by the stimulus takes priority.
            if (rx_hold_seen != rx_hold_req) begin
                rx_hold_seen = rx_hold_req;
                rx_stall = RX_HOLD;
            end else if (rx_stall == 0) begin
                rx_stall = draw_gap(rx_calm);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_item(input logic cmd, input logic [CHAN_W-1:0] ch,
                              input logic [SAMPLE_W-1:0] x);
        fir_item_t it;
        it.command = cmd;
        it.channel = ch;
        it.sample  = x;
        items_to_send.push_back(it);
    endtask

    // Writes one register while the block is idle and mirrors it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEF_PREV1:        w_prev1  = data[C1_W-1:0];
            REG_COEF_PREV2:        w_prev2  = data[C2_W-1:0];
            REG_REFRACTORY_LENGTH: refr_len = data[RL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [C1_W-1:0] c1, input logic [C2_W-1:0] c2,
                              input logic [RL_W-1:0] rl);
        write_reg(REG_COEF_PREV1, c1);
        write_reg(REG_COEF_PREV2, {1'($urandom), c2});
        write_reg(REG_REFRACTORY_LENGTH, {(CFG_DATA_W-RL_W)'($urandom), rl});
    endtask

    // Waits until every queued item is taken and every result is in, then lets
    // the pipeline settle since spikes leave nothing to wait for.
    task automatic wait_idle();
        int spins;
        spins = 0;
        do begin
            @(negedge aclk);
            spins++;
        end while (!(items_to_send.size() == 0 && !s_valid && outputs_due.size() == 0)
                   && spins < DRAIN_CAP);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'($urandom_range(0, 200) - 100);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [C1_W-1:0] rand_coef_prev1();
        case ($urandom_range(0, 5))
            0:       return C1_MOST_NEG;
            1:       return C1_MOST_POS;
            2:       return '0;
            3, 4:    return C1_W'(0 - $urandom_range(0, 131072));
            default: return C1_W'($urandom);
        endcase
    endfunction

    function automatic logic [C2_W-1:0] rand_coef_prev2();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return C2_UNITY;
            2:       return C2_ALL_ONES;
            3, 4:    return C2_W'($urandom_range(0, 65536));
            default: return C2_W'($urandom);
        endcase
    endfunction

    // Stimulus: reset, a directed part, then random phases with new settings.
    initial begin
        int ph;
        int cnt;
        int k;
        int n_act;
        int stride;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] ch;

        w_prev1  = COEF_PREV1_RST;
        w_prev2  = COEF_PREV2_RST;
        refr_len = REFRACTORY_LENGTH_RST;
        for (k = 0; k < CHANNELS; k++) begin
            hist_prev1[k] = '0;
            hist_prev2[k] = '0;
            refr_left[k]  = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: gating by a spike with the default refractory length.
        @(negedge aclk);
        queue_item(CMD_SAMPLE, 6'd0, SAMPLE_MAX);
        queue_item(CMD_SPIKE, 6'd0, SAMPLE_W'($urandom));
        queue_item(CMD_SAMPLE, 6'd0, SAMPLE_MIN);
        queue_item(CMD_SAMPLE, 6'd0, SAMPLE_MAX);
        queue_item(CMD_SAMPLE, 6'd0, SAMPLE_W'(5));
        queue_item(CMD_SAMPLE, 6'd0, SAMPLE_W'(-5));
        wait_idle();

        // Extreme weights drive the sum into both saturation limits; a spike
        // with zero refractory length clears history without gating.
        set_config(C1_MOST_NEG, C2_ALL_ONES, 3'd0);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        @(negedge aclk);
        queue_item(CMD_SAMPLE, 6'd63, SAMPLE_MAX);
        queue_item(CMD_SAMPLE, 6'd63, SAMPLE_MIN);
        queue_item(CMD_SAMPLE, 6'd63, SAMPLE_MAX);
        queue_item(CMD_SAMPLE, 6'd63, SAMPLE_MIN);
        queue_item(CMD_SPIKE, 6'd63, SAMPLE_W'($urandom));
        queue_item(CMD_SAMPLE, 6'd63, SAMPLE_MAX);
        wait_idle();

        // Longest refractory length with a positive first weight.
        set_config(C1_MOST_POS, '0, 3'd7);
        @(negedge aclk);
        queue_item(CMD_SPIKE, 6'd5, SAMPLE_W'($urandom));
        for (k = 0; k < 7; k++)
            queue_item(CMD_SAMPLE, 6'd5, rand_sample());
        wait_idle();

        // Half weights put products exactly on rounding ties of both signs.
        set_config(C1_HALF, C2_HALF, 3'd1);
        @(negedge aclk);
        queue_item(CMD_SAMPLE, 6'd9, SAMPLE_W'(1));
        queue_item(CMD_SAMPLE, 6'd9, SAMPLE_W'(-1));
        queue_item(CMD_SAMPLE, 6'd9, SAMPLE_W'(3));
        queue_item(CMD_SAMPLE, 6'd9, SAMPLE_W'(-3));
        wait_idle();

        for (ph = 0; ph < PHASES; ph++) begin
            set_config(rand_coef_prev1(), rand_coef_prev2(), RL_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            @(negedge aclk);

            // Hold the result side off while the sender keeps offering items.
            if (ph == 2) begin
                tx_steady = 1'b1;
                rx_hold_req++;
                for (k = 0; k < PRESSURE_ITEMS; k++)
                    queue_item(CMD_SAMPLE, CHAN_W'($urandom), rand_sample());
                while (items_to_send.size() != 0)
                    @(negedge aclk);
                tx_steady = 1'b0;
            end

            // Time steps over a small set of channels: spikes first, then
            // samples, with some stray items mixed in.
            n_act  = $urandom_range(1, 8);
            stride = $urandom_range(0, 1) ? 1 : 2 * $urandom_range(0, 31) + 1;
            base   = CHAN_W'($urandom);
            cnt    = 0;
            while (cnt < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8) begin
                    for (k = 0; k < n_act; k++) begin
                        ch = CHAN_W'(base + k * stride);
                        if ($urandom_range(0, 5) == 0) begin
                            queue_item(CMD_SPIKE, ch, SAMPLE_W'($urandom));
                            cnt++;
                        end
                    end
                    for (k = 0; k < n_act; k++) begin
                        ch = CHAN_W'(base + k * stride);
                        if ($urandom_range(0, 7) != 0) begin
                            queue_item(CMD_SAMPLE, ch, rand_sample());
                            cnt++;
                        end
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        queue_item(1'($urandom), CHAN_W'($urandom), SAMPLE_W'($urandom));
                        cnt++;
                    end
                end
            end
            wait_idle();
        end

        if (outputs_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outputs_due.size()));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
